// ----- sv/ishbm_pkg.sv -----
// Shared types and constants for the I/O size histogram / bandwidth meter.
// Used by the controller, datapath and divider; no dependencies.
package ishbm_pkg;

    localparam int SIZE_W    = 32;
    localparam int TIME_W    = 32;
    localparam int COUNT_W   = 32;
    localparam int RATE_W    = 48;
    localparam int WIN_W     = 16;
    localparam int ALPHA_W   = 9;
    localparam int CFG_W     = 16;
    localparam int SCALED_W  = 55;
    localparam int DIVIDEND_W = 66;
    localparam int PROD_W    = 57;
    localparam int DIV_CNT_W = 7;

    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 7'd66;

    localparam logic [RATE_W-1:0]  RATE_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [WIN_W-1:0]   WINDOW_RESET = 16'd200;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET  = 9'd77;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE    = 9'd256;

    localparam logic CFG_WINDOW_MS = 1'b0;
    localparam logic CFG_ALPHA_Q8  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_HIST,
        S_SCALE,
        S_DIV,
        S_MUL,
        S_EWMA,
        S_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic hist;
        logic div_start;
        logic mul;
        logic ewma;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic sample_due;
        logic div_done;
    } status_t;

endpackage

// ----- sv/io_size_histogram_bandwidth_meter.sv -----
// Top level of the I/O size histogram and windowed bandwidth meter.
// Depends on ishbm_pkg, ishbm_ctrl, ishbm_dp (which holds ishbm_div).
//
//   channel | signals                                         | dir
//   --------+-------------------------------------------------+-----
//   in      | in_valid, in_stall, io_size, is_write, now_ms   | in
//   out     | out_valid, out_stall, event_count, bucket_*,    | out
//           | sample_taken, read_rate, write_rate             |
//   cfg     | cfg_write, cfg_index, cfg_data                  | in
//
// A request without a rate sample goes through the lookup, histogram and done states.
// A request that closes a window also goes through scale, the bit-serial 66-step
// divider for bytes*256000/elapsed, multiply and EWMA, before the done state.
// Reset is asynchronous; the histograms read as zero until written.
// A finished result waits in the output register while the next request enters.
module io_size_histogram_bandwidth_meter
    import ishbm_pkg::*;
#(
    parameter int NUM_BUCKETS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [SIZE_W-1:0]  io_size,
    input  logic               is_write,
    input  logic [TIME_W-1:0]  now_ms,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [COUNT_W-1:0] event_count,
    output logic               bucket_valid,
    output logic [3:0]         bucket_index,
    output logic [COUNT_W-1:0] bucket_count,
    output logic               sample_taken,
    output logic [RATE_W-1:0]  read_rate,
    output logic [RATE_W-1:0]  write_rate
);

    cmd_t    cmd;
    status_t status;

    ishbm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ishbm_dp #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .io_size      (io_size),
        .is_write     (is_write),
        .now_ms       (now_ms),
        .cmd          (cmd),
        .status       (status),
        .event_count  (event_count),
        .bucket_valid (bucket_valid),
        .bucket_index (bucket_index),
        .bucket_count (bucket_count),
        .sample_taken (sample_taken),
        .read_rate    (read_rate),
        .write_rate   (write_rate)
    );

endmodule

// ----- sv/ishbm_div.sv -----
// Restoring divider, one quotient bit per cycle, saturating to the rate width.
// Depends on ishbm_pkg.
module ishbm_div
    import ishbm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [TIME_W-1:0]     divisor,
    output logic                  done,
    output logic [RATE_W-1:0]     quotient
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] num_reg, num_next;
    logic [TIME_W-1:0]     rem_reg, rem_next;
    logic [TIME_W-1:0]     den_reg, den_next;
    logic [RATE_W-1:0]     q_reg, q_next;
    logic                  sat_reg, sat_next;
    logic [TIME_W:0]       shifted;
    logic [TIME_W+1:0]     diff;
    logic                  qbit;

    always_comb
    begin
        shifted   = {rem_reg, num_reg[DIVIDEND_W-1]};
        diff      = {1'b0, shifted} - {2'b00, den_reg};
        qbit      = ~diff[TIME_W+1];
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        sat_next  = sat_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_STEPS;
            num_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            q_next    = '0;
            sat_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[DIVIDEND_W-2:0], 1'b0};
            rem_next = qbit ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
            q_next   = {q_reg[RATE_W-2:0], qbit};
            sat_next = sat_reg | q_reg[RATE_W-1];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
        sat_reg <= sat_next;
    end

    assign done     = done_reg;
    assign quotient = sat_reg ? RATE_MAX : q_reg;

endmodule

// ----- sv/ishbm_dp.sv -----
// Datapath: config registers, histogram memory, window accounting, rate EWMA.
// Depends on ishbm_pkg and ishbm_div.
module ishbm_dp
    import ishbm_pkg::*;
#(
    parameter int NUM_BUCKETS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic [SIZE_W-1:0]  io_size,
    input  logic               is_write,
    input  logic [TIME_W-1:0]  now_ms,
    input  cmd_t               cmd,
    output status_t            status,
    output logic [COUNT_W-1:0] event_count,
    output logic               bucket_valid,
    output logic [3:0]         bucket_index,
    output logic [COUNT_W-1:0] bucket_count,
    output logic               sample_taken,
    output logic [RATE_W-1:0]  read_rate,
    output logic [RATE_W-1:0]  write_rate
);

    localparam int BW     = $clog2(NUM_BUCKETS);
    localparam int LAST   = NUM_BUCKETS - 1;
    localparam int HDEPTH = 2 * (2 ** BW);

    function automatic logic [4:0] floor_log2(input logic [SIZE_W-1:0] v);
        logic [4:0] n;
        n = '0;
        for (int i = 1; i < SIZE_W; i++)
        begin
            if (v[i])
                n = 5'(i);
        end
        return n;
    endfunction

    logic [WIN_W-1:0]   window_ms_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic               wr_reg;
    logic [TIME_W-1:0]  now_reg;
    logic               started_reg;
    logic [TIME_W-1:0]  start_ms_reg;
    logic [COUNT_W-1:0] event_reg;
    logic [RATE_W-1:0]  rwb_reg, wwb_reg;
    logic [RATE_W-1:0]  ravg_reg, wavg_reg;
    logic               due_reg;
    logic [TIME_W-1:0]  elapsed_reg;
    logic [PROD_W-1:0]  p1_reg, p2_reg;

    logic [COUNT_W-1:0] hist_mem [HDEPTH];
    logic [HDEPTH-1:0]  hist_valid_reg;
    logic [COUNT_W-1:0] hist_rd_reg;

    logic               bvalid_reg;
    logic [3:0]         bidx_reg;
    logic [COUNT_W-1:0] bcount_reg;

    logic [COUNT_W-1:0] out_event_reg;
    logic               out_bvalid_reg;
    logic [3:0]         out_bidx_reg;
    logic [COUNT_W-1:0] out_bcount_reg;
    logic               out_taken_reg;
    logic [RATE_W-1:0]  out_rrate_reg, out_wrate_reg;

    logic [4:0]         lg;
    logic [BW-1:0]      bucket;
    logic [BW+3:0]      bucket_ext;
    logic [BW:0]        haddr;
    logic               size_nz;
    logic [COUNT_W-1:0] hist_cur, hist_inc;
    logic [TIME_W-1:0]  elapsed;
    logic [WIN_W-1:0]   win;
    logic [RATE_W-1:0]  dir_bytes;
    logic [RATE_W:0]    bytes_sum;
    logic [RATE_W-1:0]  bytes_sat;
    logic [SCALED_W-1:0] scaled;
    logic [RATE_W-1:0]  sample;
    logic [ALPHA_W-1:0] alpha_eff;
    logic [ALPHA_W-1:0] alpha_inv;
    logic [RATE_W-1:0]  dir_avg;
    logic [PROD_W-1:0]  ewma_sum;
    logic               div_done;

    always_comb
    begin
        lg         = floor_log2(size_reg);
        bucket     = (int'(lg) > LAST) ? BW'(LAST) : BW'(lg);
        bucket_ext = {4'b0000, bucket};
        haddr      = {wr_reg, bucket};
        size_nz    = (size_reg != '0);
        hist_cur   = hist_valid_reg[haddr] ? hist_rd_reg : '0;
        hist_inc   = (hist_cur == COUNT_MAX) ? hist_cur : hist_cur + 1'b1;
        elapsed    = now_reg - start_ms_reg;
        win        = (window_ms_reg == '0) ? 16'd1 : window_ms_reg;
        dir_bytes  = wr_reg ? wwb_reg : rwb_reg;
        bytes_sum  = {1'b0, dir_bytes} + (RATE_W+1)'(size_reg);
        bytes_sat  = bytes_sum[RATE_W] ? RATE_MAX : bytes_sum[RATE_W-1:0];
        // bytes * 125, the remaining factor 2^11 of 256000 is a shift
        scaled     = {dir_bytes, 7'b0} - {6'b0, dir_bytes, 1'b0} - {7'b0, dir_bytes};
        alpha_eff  = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
        alpha_inv  = ALPHA_ONE - alpha_eff;
        dir_avg    = wr_reg ? wavg_reg : ravg_reg;
        ewma_sum   = p1_reg + p2_reg;
    end

    ishbm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({scaled, 11'b0}),
        .divisor  (elapsed_reg),
        .done     (div_done),
        .quotient (sample)
    );

    assign status = {due_reg, div_done};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ms_reg  <= WINDOW_RESET;
            alpha_reg      <= ALPHA_RESET;
            started_reg    <= 1'b0;
            start_ms_reg   <= '0;
            event_reg      <= '0;
            rwb_reg        <= '0;
            wwb_reg        <= '0;
            ravg_reg       <= '0;
            wavg_reg       <= '0;
            due_reg        <= 1'b0;
            hist_valid_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_WINDOW_MS: window_ms_reg <= cfg_data;
                    CFG_ALPHA_Q8:  alpha_reg <= cfg_data[ALPHA_W-1:0];
                    default:       window_ms_reg <= window_ms_reg;
                endcase
            end
            if (cmd.lookup)
            begin
                if (event_reg != COUNT_MAX)
                    event_reg <= event_reg + 1'b1;
                if (!started_reg)
                begin
                    started_reg  <= 1'b1;
                    start_ms_reg <= now_reg;
                    due_reg      <= 1'b0;
                end
                else
                begin
                    if (wr_reg)
                        wwb_reg <= bytes_sat;
                    else
                        rwb_reg <= bytes_sat;
                    due_reg <= (elapsed >= TIME_W'(win));
                end
            end
            if (cmd.hist && size_nz)
                hist_valid_reg[haddr] <= 1'b1;
            if (cmd.ewma)
            begin
                if (wr_reg)
                begin
                    wavg_reg <= ewma_sum[RATE_W+7:8];
                    wwb_reg  <= '0;
                end
                else
                begin
                    ravg_reg <= ewma_sum[RATE_W+7:8];
                    rwb_reg  <= '0;
                end
                start_ms_reg <= now_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            size_reg <= io_size;
            wr_reg   <= is_write;
            now_reg  <= now_ms;
        end
        if (cmd.lookup)
        begin
            hist_rd_reg <= hist_mem[haddr];
            elapsed_reg <= elapsed;
        end
        if (cmd.hist)
        begin
            if (size_nz)
                hist_mem[haddr] <= hist_inc;
            bvalid_reg <= size_nz;
            bidx_reg   <= size_nz ? bucket_ext[3:0] : 4'd0;
            bcount_reg <= size_nz ? hist_inc : '0;
        end
        if (cmd.mul)
        begin
            p1_reg <= PROD_W'(alpha_eff) * PROD_W'(sample);
            p2_reg <= PROD_W'(alpha_inv) * PROD_W'(dir_avg);
        end
        if (cmd.load_out)
        begin
            out_event_reg  <= event_reg;
            out_bvalid_reg <= bvalid_reg;
            out_bidx_reg   <= bidx_reg;
            out_bcount_reg <= bcount_reg;
            out_taken_reg  <= due_reg;
            out_rrate_reg  <= ravg_reg;
            out_wrate_reg  <= wavg_reg;
        end
    end

    assign event_count  = out_event_reg;
    assign bucket_valid = out_bvalid_reg;
    assign bucket_index = out_bidx_reg;
    assign bucket_count = out_bcount_reg;
    assign sample_taken = out_taken_reg;
    assign read_rate    = out_rrate_reg;
    assign write_rate   = out_wrate_reg;

endmodule

// ----- sv/ishbm_ctrl.sv -----
// Controller state machine: sequences one request through the datapath.
// Depends on ishbm_pkg.
module ishbm_ctrl
    import ishbm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = S_HIST;
            end
            S_HIST:
            begin
                cmd.hist   = 1'b1;
                state_next = status.sample_due ? S_SCALE : S_DONE;
            end
            S_SCALE:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (status.div_done)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_EWMA;
            end
            S_EWMA:
            begin
                cmd.ewma   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule
